// ===== rtl/core/char_lcd_text_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the character display text sequencer
// Concurrent checks on i_clk, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_TEXT_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_TEXT_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
// checked outside reset only
`define CLTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// checked on every edge, reset included
`define CLTS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define CLTS_ASSERT(lbl, prop, msg)
`define CLTS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/clts_pkg.sv =====
// ----------------------------------------------------------------------------
// clts_pkg
// Types and display command bytes shared by the text sequencer modules.
// ----------------------------------------------------------------------------
package clts_pkg;

    typedef enum logic [2:0] {
        CMD_PUT_CHAR   = 3'd0,
        CMD_SET_CURSOR = 3'd1,
        CMD_CLEAR      = 3'd2,
        CMD_INIT       = 3'd3,
        CMD_DEF_GLYPH  = 3'd4,
        CMD_PUT_GLYPH  = 3'd5
    } t_cmd;

    localparam logic [1:0] ROW_LINE1 = 2'd1;
    localparam logic [1:0] ROW_LINE2 = 2'd2;

    // controller instruction bytes
    localparam logic [7:0] LCD_LINE1_ADDR = 8'h80;
    localparam logic [7:0] LCD_LINE2_ADDR = 8'hC0;
    localparam logic [7:0] LCD_CGRAM_ADDR = 8'h40;
    localparam logic [7:0] LCD_FUNC_SET   = 8'h28;
    localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] LCD_DISP_ON    = 8'h0C;
    localparam logic [7:0] LCD_DISP_CLR   = 8'h01;
    localparam logic [7:0] LCD_HOME       = 8'h02;

    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    localparam int MAX_BYTES  = 9;
    localparam int BYTE_IDX_W = $clog2(MAX_BYTES);
    localparam int NBYTES_W   = $clog2(MAX_BYTES + 1);

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  char_code;
        logic [1:0]  row;
        logic [4:0]  col;
        logic [2:0]  glyph_slot;
        logic [63:0] glyph_rows;
    } t_in_item;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] nibble;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic       rs;
        logic [7:0] data;
    } t_lcd_byte;

    // byte list produced by one request, entry 0 goes out first
    typedef struct packed {
        logic [NBYTES_W-1:0]          nbytes;
        t_lcd_byte [MAX_BYTES-1:0]    bytes;
    } t_seq;

endpackage

// ===== rtl/core/clts_cmd_decode.sv =====
// ----------------------------------------------------------------------------
// clts_cmd_decode
// Turns one request into its list of bus bytes and the next cursor state.
// ----------------------------------------------------------------------------
module clts_cmd_decode #(
    parameter int LINE_WIDTH = 16,
    localparam int CNT_W = $clog2(2 * LINE_WIDTH + 1),
    localparam int COL_W = $clog2(LINE_WIDTH + 1)
) (
    input  clts_pkg::t_in_item i_item,
    input  logic [CNT_W-1:0]   i_cnt,
    input  logic [1:0]         i_row,
    input  logic [COL_W-1:0]   i_col,
    output clts_pkg::t_seq     o_seq,
    output logic [CNT_W-1:0]   o_cnt,
    output logic [1:0]         o_row,
    output logic [COL_W-1:0]   o_col
);

    localparam logic [CNT_W-1:0] LW_C  = CNT_W'(LINE_WIDTH);
    localparam logic [CNT_W-1:0] LW2_C = CNT_W'(2 * LINE_WIDTH);

    clts_pkg::t_cmd       cmd;
    logic [1:0]           sc_row;
    logic [5:0]           sc_col6;
    logic [COL_W-1:0]     sc_cl;
    logic                 sc_ok;
    clts_pkg::t_lcd_byte  sc_byte;
    logic [CNT_W-1:0]     sc_cnt;
    logic [CNT_W-1:0]     cnt_inc;

    assign cmd = clts_pkg::t_cmd'(i_item.cmd);

    // shared set-cursor path; put glyph re-addresses the stored position
    always_comb begin
        if (cmd == clts_pkg::CMD_PUT_GLYPH) begin
            sc_row  = i_row;
            sc_col6 = 6'(i_col);
        end else begin
            sc_row  = i_item.row;
            sc_col6 = 6'(i_item.col);
        end

        if (sc_col6 == 6'd0) begin
            sc_cl = COL_W'(1);
        end else if (32'(sc_col6) > 32'(LINE_WIDTH)) begin
            sc_cl = COL_W'(LINE_WIDTH);
        end else begin
            sc_cl = COL_W'(sc_col6);
        end

        sc_ok      = (sc_row == clts_pkg::ROW_LINE1) || (sc_row == clts_pkg::ROW_LINE2);
        sc_byte.rs = clts_pkg::RS_CMD;
        if (sc_row == clts_pkg::ROW_LINE2) begin
            sc_byte.data = clts_pkg::LCD_LINE2_ADDR + 8'(sc_cl) - 8'd1;
            sc_cnt       = LW_C + CNT_W'(sc_cl) - CNT_W'(1);
        end else begin
            sc_byte.data = clts_pkg::LCD_LINE1_ADDR + 8'(sc_cl) - 8'd1;
            sc_cnt       = CNT_W'(sc_cl) - CNT_W'(1);
        end

        cnt_inc = (i_cnt < LW2_C) ? i_cnt + CNT_W'(1) : i_cnt;
    end

    always_comb begin
        o_seq = '0;
        o_cnt = i_cnt;
        o_row = i_row;
        o_col = i_col;

        unique case (cmd)
            clts_pkg::CMD_PUT_CHAR: begin
                o_seq.bytes[0] = '{rs: clts_pkg::RS_DATA, data: i_item.char_code};
                o_cnt          = cnt_inc;
                if ((cnt_inc < LW_C) || ((cnt_inc > LW_C) && (cnt_inc < LW2_C))) begin
                    o_seq.nbytes = clts_pkg::NBYTES_W'(1);
                    if (i_col < COL_W'(LINE_WIDTH)) begin
                        o_col = i_col + COL_W'(1);
                    end
                end else if (cnt_inc == LW_C) begin
                    // line 1 full: move to start of line 2
                    o_seq.nbytes   = clts_pkg::NBYTES_W'(2);
                    o_seq.bytes[1] = '{rs: clts_pkg::RS_CMD, data: clts_pkg::LCD_LINE2_ADDR};
                    o_row          = clts_pkg::ROW_LINE2;
                    o_col          = COL_W'(1);
                end else begin
                    // line 2 full: wrap to start of line 1
                    o_seq.nbytes   = clts_pkg::NBYTES_W'(2);
                    o_seq.bytes[1] = '{rs: clts_pkg::RS_CMD, data: clts_pkg::LCD_LINE1_ADDR};
                    o_row          = clts_pkg::ROW_LINE1;
                    o_col          = COL_W'(1);
                    o_cnt          = '0;
                end
            end
            clts_pkg::CMD_SET_CURSOR: begin
                if (sc_ok) begin
                    o_seq.nbytes   = clts_pkg::NBYTES_W'(1);
                    o_seq.bytes[0] = sc_byte;
                    o_cnt          = sc_cnt;
                    o_row          = sc_row;
                    o_col          = sc_cl;
                end
            end
            clts_pkg::CMD_CLEAR: begin
                o_seq.nbytes   = clts_pkg::NBYTES_W'(2);
                o_seq.bytes[0] = '{rs: clts_pkg::RS_CMD, data: clts_pkg::LCD_DISP_CLR};
                o_seq.bytes[1] = '{rs: clts_pkg::RS_CMD, data: clts_pkg::LCD_HOME};
                o_cnt          = '0;
                o_row          = clts_pkg::ROW_LINE1;
                o_col          = COL_W'(1);
            end
            clts_pkg::CMD_INIT: begin
                o_seq.nbytes   = clts_pkg::NBYTES_W'(5);
                o_seq.bytes[0] = '{rs: clts_pkg::RS_CMD, data: clts_pkg::LCD_DISP_CLR};
                o_seq.bytes[1] = '{rs: clts_pkg::RS_CMD, data: clts_pkg::LCD_HOME};
                o_seq.bytes[2] = '{rs: clts_pkg::RS_CMD, data: clts_pkg::LCD_FUNC_SET};
                o_seq.bytes[3] = '{rs: clts_pkg::RS_CMD, data: clts_pkg::LCD_ENTRY_MODE};
                o_seq.bytes[4] = '{rs: clts_pkg::RS_CMD, data: clts_pkg::LCD_DISP_ON};
                o_cnt          = '0;
                o_row          = clts_pkg::ROW_LINE1;
                o_col          = COL_W'(1);
            end
            clts_pkg::CMD_DEF_GLYPH: begin
                o_seq.nbytes   = clts_pkg::NBYTES_W'(clts_pkg::MAX_BYTES);
                o_seq.bytes[0] = '{rs: clts_pkg::RS_CMD,
                                   data: clts_pkg::LCD_CGRAM_ADDR
                                         | {2'b00, i_item.glyph_slot, 3'b000}};
                for (int i = 0; i < 8; i++) begin
                    o_seq.bytes[i+1] = '{rs: clts_pkg::RS_DATA,
                                         data: i_item.glyph_rows[8*i +: 8]};
                end
            end
            clts_pkg::CMD_PUT_GLYPH: begin
                if (sc_ok) begin
                    o_seq.nbytes   = clts_pkg::NBYTES_W'(2);
                    o_seq.bytes[0] = sc_byte;
                    o_seq.bytes[1] = '{rs: clts_pkg::RS_DATA,
                                       data: {5'b00000, i_item.glyph_slot}};
                    // column stays put, count steps past the glyph
                    o_cnt          = sc_cnt + CNT_W'(1);
                    o_row          = sc_row;
                    o_col          = sc_cl;
                end else begin
                    o_seq.nbytes   = clts_pkg::NBYTES_W'(1);
                    o_seq.bytes[0] = '{rs: clts_pkg::RS_DATA,
                                       data: {5'b00000, i_item.glyph_slot}};
                    o_cnt          = cnt_inc;
                end
            end
            default: begin
                // undefined command codes: nothing sent, state kept
            end
        endcase
    end

endmodule

// ===== rtl/core/char_lcd_text_sequencer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_text_sequencer
// Two-line character display text sequencer for a 4-bit controller bus.
// ----------------------------------------------------------------------------
// Each request is decoded in the cycle it is accepted into a list of up to
// nine bus bytes, which leave as nibbles, high nibble first, one per cycle
// while the output is not stalled, through a single output register. A
// request sends two nibbles per byte: 2 for a plain character, 4 when a
// character fills a line or for put glyph and clear, 10 for init, 18 for
// define glyph, none for a request that sends nothing. The next request
// is accepted in the cycle the previous request's last nibble enters the
// output register, so the output runs without gaps. Enable strobes and
// bus timing are the job of the physical layer behind this block.
// ----------------------------------------------------------------------------
`include "char_lcd_text_sequencer_assert.svh"

module char_lcd_text_sequencer #(
    parameter int LINE_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  clts_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output clts_pkg::t_out_item  o_out_item
);

    localparam int CNT_W = $clog2(2 * LINE_WIDTH + 1);
    localparam int COL_W = $clog2(LINE_WIDTH + 1);
    localparam logic [CNT_W-1:0] LW2_C = CNT_W'(2 * LINE_WIDTH);

    logic [CNT_W-1:0]                r_cnt;
    logic [1:0]                      r_row;
    logic [COL_W-1:0]                r_col;
    logic [CNT_W-1:0]                n_cnt;
    logic [1:0]                      n_row;
    logic [COL_W-1:0]                n_col;
    clts_pkg::t_seq                  n_seq;

    clts_pkg::t_seq                  r_seq;
    logic                            r_busy;
    logic [clts_pkg::BYTE_IDX_W-1:0] r_byte;
    logic [clts_pkg::BYTE_IDX_W-1:0] r_last_idx;
    logic                            r_half;

    logic                            r_out_valid;
    clts_pkg::t_out_item             r_out;

    logic                            emit_go;
    logic                            buf_done;
    logic                            in_acc;
    clts_pkg::t_lcd_byte             cur_byte;
    clts_pkg::t_out_item             n_out;

    clts_cmd_decode #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_decode (
        .i_item (i_in_item),
        .i_cnt  (r_cnt),
        .i_row  (r_row),
        .i_col  (r_col),
        .o_seq  (n_seq),
        .o_cnt  (n_cnt),
        .o_row  (n_row),
        .o_col  (n_col)
    );

    // a nibble moves on whenever the output register is free or being taken
    assign emit_go    = r_busy && (!r_out_valid || !i_out_stall);
    assign buf_done   = emit_go && r_half && (r_byte == r_last_idx);
    assign o_in_stall = r_busy && !buf_done;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        cur_byte         = r_seq.bytes[r_byte];
        n_out.reg_select = cur_byte.rs;
        n_out.nibble     = r_half ? cur_byte.data[3:0] : cur_byte.data[7:4];
        n_out.last       = r_half && (r_byte == r_last_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_row  <= clts_pkg::ROW_LINE1;
            r_col  <= COL_W'(1);
            r_busy <= 1'b0;
            r_byte <= '0;
            r_half <= 1'b0;
        end else if (in_acc) begin
            r_cnt  <= n_cnt;
            r_row  <= n_row;
            r_col  <= n_col;
            r_busy <= (n_seq.nbytes != '0);
            r_byte <= '0;
            r_half <= 1'b0;
        end else if (emit_go) begin
            r_half <= !r_half;
            if (r_half) begin
                r_byte <= r_byte + clts_pkg::BYTE_IDX_W'(1);
            end
            if (buf_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // byte list payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_seq      <= n_seq;
            r_last_idx <= clts_pkg::BYTE_IDX_W'(n_seq.nbytes - clts_pkg::NBYTES_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `CLTS_ASSERT(a_row_legal, r_row == clts_pkg::ROW_LINE1 || r_row == clts_pkg::ROW_LINE2, "cursor row left lines 1 and 2")
    `CLTS_ASSERT(a_cnt_sat, r_cnt <= LW2_C, "character count above two full lines")
    `CLTS_ASSERT(a_col_legal, r_col != '0 && 32'(r_col) <= 32'(LINE_WIDTH), "cursor column out of range")
    `CLTS_ASSERT(a_buf_drains, buf_done && !in_acc |=> !r_busy, "byte list still busy after its last nibble")
    `CLTS_ASSERT_RST(a_reset_idle, !i_rst_n |=> !r_out_valid && !r_busy, "sequencer not idle after reset")

endmodule
